@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the assertion checker in hw/rtl/dlu_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DLU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define DLU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dlu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dlu_pkg;

    localparam int OUT_CAP   = 16;
    localparam int CW        = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    localparam logic [1:0] REQ_WRITE_MAT = 2'd0;
    localparam logic [1:0] REQ_FACTOR    = 2'd1;
    localparam logic [1:0] REQ_WRITE_RHS = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_SINGULAR  = 2'd1;
    localparam logic [1:0] STAT_NO_FACTOR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_MIN   = 2'd1;

    typedef enum logic {
        OP_MULSUB = 1'b0,
        OP_DIV    = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic               start;
        arith_op_t          op;
        logic signed [31:0] a;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } arith_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] result;
    } arith_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/dense_lu_solver.sv @@
// Load items (matrix entry, rhs element without the last mark) are written when
// accepted and leave the block idle. A factor item divides the subdiagonal entries
// and updates trailing entries, O(n^3), on the shared multiply/48-step divide unit.
// A solve runs multiply-subtracts and a divide per diagonal entry, then emits its
// elements in order; no new item is taken until the last result.
// Reset is asynchronous and active low; matrix_size returns to 16, pivot_min to 1.
`timescale 1ns / 1ps
`default_nettype none

module dense_lu_solver #(
    parameter int MAX_N = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [1:0]                          req_type,
    input  logic [3:0]                          row,
    input  logic [3:0]                          col,
    input  logic signed [31:0]                  value,
    input  logic                                last_element,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic [3:0]                          index,
    output logic signed [31:0]                  solution,
    output logic [1:0]                          status,
    output logic                                last_result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dlu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dlu_pkg::CFG_DAT_W-1:0]       cfg_data
);
    import dlu_pkg::*;

    localparam int AW   = $clog2(MAX_N * MAX_N);
    localparam int VW   = $clog2(MAX_N);
    localparam int NCAP = (MAX_N < OUT_CAP) ? MAX_N : OUT_CAP;

    typedef enum logic [22:0] {
        IDLE       = 23'h000001,
        F_PIV_RD   = 23'h000002,
        F_PIV_CHK  = 23'h000004,
        F_DIV_RD   = 23'h000008,
        F_DIV_GO   = 23'h000010,
        F_DIV_WAIT = 23'h000020,
        F_UPD_IK   = 23'h000040,
        F_UPD_KJ   = 23'h000080,
        F_UPD_IJ   = 23'h000100,
        F_UPD_GO   = 23'h000200,
        F_UPD_WAIT = 23'h000400,
        S_RD_I     = 23'h000800,
        S_LD_I     = 23'h001000,
        S_RD_J     = 23'h002000,
        S_MS_GO    = 23'h004000,
        S_MS_WAIT  = 23'h008000,
        S_RD_D     = 23'h010000,
        S_DIV_GO   = 23'h020000,
        S_DIV_WAIT = 23'h040000,
        S_WR_I     = 23'h080000,
        S_OUT_RD   = 23'h100000,
        S_OUT_LD   = 23'h200000,
        O_WAIT     = 23'h400000
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic               bwd_reg;
    logic               fvalid_reg;
    logic [4:0]         msize_reg;
    logic [16:0]        pmin_reg;
    logic signed [31:0] piv_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] ukj_reg;
    logic               ovalid_reg;
    logic [3:0]         oidx_reg;
    logic signed [31:0] osol_reg;
    logic [1:0]         ostat_reg;
    logic               olast_reg;

    logic signed [31:0] mat_mem [MAX_N*MAX_N];
    logic signed [31:0] vec_mem [MAX_N];
    logic signed [31:0] mrd_reg;
    logic signed [31:0] vrd_reg;

    logic [AW-1:0]      mra;
    logic [AW-1:0]      mwa;
    logic               mwe;
    logic signed [31:0] mwd;
    logic [VW-1:0]      vra;
    logic [VW-1:0]      vwa;
    logic               vwe;
    logic signed [31:0] vwd;

    logic [CW-1:0]      n_use;
    logic               accept;
    logic               row_ok;
    logic               col_ok;
    logic [32:0]        piv_mag;
    logic               singular;
    arith_req_t         areq;
    arith_rsp_t         arsp;

    function automatic logic [AW-1:0] madr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(AW'(r) * AW'(MAX_N) + AW'(c));
    endfunction

    always_comb
    begin
        if (msize_reg == 5'd0)
        begin
            n_use = CW'(1);
        end
        else if (int'(msize_reg) > NCAP)
        begin
            n_use = CW'(NCAP);
        end
        else
        begin
            n_use = msize_reg;
        end
    end

    assign req_stall = (state_reg != IDLE);
    assign accept    = req_valid && !req_stall;
    assign row_ok    = int'(row) < MAX_N;
    assign col_ok    = int'(col) < MAX_N;
    assign cfg_ready = 1'b1;
    assign piv_mag   = mrd_reg[31] ? (33'd0 - 33'(mrd_reg)) : 33'(mrd_reg);
    assign singular  = (mrd_reg == 32'sd0) || (piv_mag < {16'd0, pmin_reg});

    always_comb
    begin
        unique case (state_reg)
            F_PIV_RD: mra = madr(k_reg, k_reg);
            F_DIV_RD: mra = madr(i_reg, k_reg);
            F_UPD_IK: mra = madr(i_reg, k_reg);
            F_UPD_KJ: mra = madr(k_reg, j_reg);
            S_RD_D:   mra = madr(i_reg, i_reg);
            default:  mra = madr(i_reg, j_reg);
        endcase
    end

    assign vra = (state_reg == S_RD_J) ? VW'(j_reg) : VW'(i_reg);

    always_comb
    begin
        mwe = 1'b0;
        mwa = madr(CW'(row), CW'(col));
        mwd = value;
        if (accept && req_type == REQ_WRITE_MAT && row_ok && col_ok)
        begin
            mwe = 1'b1;
        end
        else if (state_reg == F_DIV_WAIT && arsp.done)
        begin
            mwe = 1'b1;
            mwa = madr(i_reg, k_reg);
            mwd = arsp.result;
        end
        else if (state_reg == F_UPD_WAIT && arsp.done)
        begin
            mwe = 1'b1;
            mwa = madr(i_reg, j_reg);
            mwd = arsp.result;
        end
    end

    always_comb
    begin
        vwe = 1'b0;
        vwa = VW'(row);
        vwd = value;
        if (accept && req_type == REQ_WRITE_RHS && row_ok)
        begin
            vwe = 1'b1;
        end
        else if (state_reg == S_WR_I)
        begin
            vwe = 1'b1;
            vwa = VW'(i_reg);
            vwd = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            mat_mem[mwa] <= mwd;
        end
        mrd_reg <= mat_mem[mra];
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
        begin
            vec_mem[vwa] <= vwd;
        end
        vrd_reg <= vec_mem[vra];
    end

    always_comb
    begin
        areq.start = 1'b0;
        areq.op    = OP_MULSUB;
        areq.a     = acc_reg;
        areq.x     = vrd_reg;
        areq.y     = mrd_reg;
        unique case (state_reg)
            F_DIV_GO:
            begin
                areq.start = 1'b1;
                areq.op    = OP_DIV;
                areq.a     = mrd_reg;
                areq.y     = piv_reg;
            end
            F_UPD_GO:
            begin
                areq.start = 1'b1;
                areq.a     = mrd_reg;
                areq.x     = acc_reg;
                areq.y     = ukj_reg;
            end
            S_MS_GO:
            begin
                areq.start = 1'b1;
            end
            S_DIV_GO:
            begin
                areq.start = 1'b1;
                areq.op    = OP_DIV;
            end
            default:
            begin
                areq.start = 1'b0;
            end
        endcase
    end

    dlu_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (areq),
        .rsp   (arsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            k_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            bwd_reg    <= 1'b0;
            fvalid_reg <= 1'b0;
            msize_reg  <= 5'd16;
            pmin_reg   <= 17'd1;
            piv_reg    <= '0;
            acc_reg    <= '0;
            ukj_reg    <= '0;
            ovalid_reg <= 1'b0;
            oidx_reg   <= '0;
            osol_reg   <= '0;
            ostat_reg  <= STAT_OK;
            olast_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MATRIX_SIZE)
                begin
                    msize_reg  <= cfg_data[4:0];
                    fvalid_reg <= 1'b0;
                end
                else if (cfg_index == CFG_PIVOT_MIN)
                begin
                    pmin_reg <= cfg_data;
                end
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        case (req_type)
                            REQ_WRITE_MAT:
                            begin
                                if (row_ok && col_ok)
                                begin
                                    fvalid_reg <= 1'b0;
                                end
                            end
                            REQ_FACTOR:
                            begin
                                fvalid_reg <= 1'b0;
                                k_reg      <= '0;
                                state_reg  <= F_PIV_RD;
                            end
                            REQ_WRITE_RHS:
                            begin
                                if (last_element)
                                begin
                                    if (!fvalid_reg)
                                    begin
                                        oidx_reg   <= '0;
                                        osol_reg   <= '0;
                                        ostat_reg  <= STAT_NO_FACTOR;
                                        olast_reg  <= 1'b1;
                                        ovalid_reg <= 1'b1;
                                        state_reg  <= O_WAIT;
                                    end
                                    else
                                    begin
                                        bwd_reg   <= (n_use == CW'(1));
                                        i_reg     <= (n_use == CW'(1)) ? CW'(0) : CW'(1);
                                        state_reg <= S_RD_I;
                                    end
                                end
                            end
                            default:
                            begin
                                state_reg <= IDLE;
                            end
                        endcase
                    end
                end
                F_PIV_RD:
                begin
                    state_reg <= F_PIV_CHK;
                end
                F_PIV_CHK:
                begin
                    piv_reg <= mrd_reg;
                    if (singular)
                    begin
                        oidx_reg   <= '0;
                        osol_reg   <= '0;
                        ostat_reg  <= STAT_SINGULAR;
                        olast_reg  <= 1'b1;
                        ovalid_reg <= 1'b1;
                        state_reg  <= O_WAIT;
                    end
                    else if (k_reg + CW'(1) == n_use)
                    begin
                        fvalid_reg <= 1'b1;
                        oidx_reg   <= '0;
                        osol_reg   <= '0;
                        ostat_reg  <= STAT_OK;
                        olast_reg  <= 1'b1;
                        ovalid_reg <= 1'b1;
                        state_reg  <= O_WAIT;
                    end
                    else
                    begin
                        i_reg     <= k_reg + CW'(1);
                        state_reg <= F_DIV_RD;
                    end
                end
                F_DIV_RD:
                begin
                    state_reg <= F_DIV_GO;
                end
                F_DIV_GO:
                begin
                    state_reg <= F_DIV_WAIT;
                end
                F_DIV_WAIT:
                begin
                    if (arsp.done)
                    begin
                        if (i_reg + CW'(1) < n_use)
                        begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= F_DIV_RD;
                        end
                        else
                        begin
                            i_reg     <= k_reg + CW'(1);
                            j_reg     <= k_reg + CW'(1);
                            state_reg <= F_UPD_IK;
                        end
                    end
                end
                F_UPD_IK:
                begin
                    state_reg <= F_UPD_KJ;
                end
                F_UPD_KJ:
                begin
                    acc_reg   <= mrd_reg;
                    state_reg <= F_UPD_IJ;
                end
                F_UPD_IJ:
                begin
                    ukj_reg   <= mrd_reg;
                    state_reg <= F_UPD_GO;
                end
                F_UPD_GO:
                begin
                    state_reg <= F_UPD_WAIT;
                end
                F_UPD_WAIT:
                begin
                    if (arsp.done)
                    begin
                        if (j_reg + CW'(1) < n_use)
                        begin
                            j_reg     <= j_reg + CW'(1);
                            state_reg <= F_UPD_IK;
                        end
                        else if (i_reg + CW'(1) < n_use)
                        begin
                            i_reg     <= i_reg + CW'(1);
                            j_reg     <= k_reg + CW'(1);
                            state_reg <= F_UPD_IK;
                        end
                        else
                        begin
                            k_reg     <= k_reg + CW'(1);
                            state_reg <= F_PIV_RD;
                        end
                    end
                end
                S_RD_I:
                begin
                    state_reg <= S_LD_I;
                end
                S_LD_I:
                begin
                    acc_reg <= vrd_reg;
                    if (!bwd_reg)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_RD_J;
                    end
                    else if (i_reg + CW'(1) < n_use)
                    begin
                        j_reg     <= n_use - CW'(1);
                        state_reg <= S_RD_J;
                    end
                    else
                    begin
                        state_reg <= S_RD_D;
                    end
                end
                S_RD_J:
                begin
                    state_reg <= S_MS_GO;
                end
                S_MS_GO:
                begin
                    state_reg <= S_MS_WAIT;
                end
                S_MS_WAIT:
                begin
                    if (arsp.done)
                    begin
                        acc_reg <= arsp.result;
                        if (!bwd_reg)
                        begin
                            if (j_reg + CW'(1) < i_reg)
                            begin
                                j_reg     <= j_reg + CW'(1);
                                state_reg <= S_RD_J;
                            end
                            else
                            begin
                                state_reg <= S_WR_I;
                            end
                        end
                        else if (j_reg - CW'(1) > i_reg)
                        begin
                            j_reg     <= j_reg - CW'(1);
                            state_reg <= S_RD_J;
                        end
                        else
                        begin
                            state_reg <= S_RD_D;
                        end
                    end
                end
                S_RD_D:
                begin
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (arsp.done)
                    begin
                        acc_reg   <= arsp.result;
                        state_reg <= S_WR_I;
                    end
                end
                S_WR_I:
                begin
                    if (!bwd_reg)
                    begin
                        if (i_reg + CW'(1) < n_use)
                        begin
                            i_reg <= i_reg + CW'(1);
                        end
                        else
                        begin
                            bwd_reg <= 1'b1;
                            i_reg   <= n_use - CW'(1);
                        end
                        state_reg <= S_RD_I;
                    end
                    else if (i_reg == '0)
                    begin
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg - CW'(1);
                        state_reg <= S_RD_I;
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_LD;
                end
                S_OUT_LD:
                begin
                    oidx_reg   <= i_reg[3:0];
                    osol_reg   <= vrd_reg;
                    ostat_reg  <= STAT_OK;
                    olast_reg  <= (i_reg + CW'(1) == n_use);
                    ovalid_reg <= 1'b1;
                    state_reg  <= O_WAIT;
                end
                O_WAIT:
                begin
                    if (!res_stall)
                    begin
                        ovalid_reg <= 1'b0;
                        if (olast_reg)
                        begin
                            state_reg <= IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign res_valid   = ovalid_reg;
    assign index       = oidx_reg;
    assign solution    = osol_reg;
    assign status      = ostat_reg;
    assign last_result = olast_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dlu_arith.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dlu_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  dlu_pkg::arith_req_t req,
    output dlu_pkg::arith_rsp_t rsp
);
    import dlu_pkg::*;

    localparam int DIV_STEPS = 48;

    typedef enum logic [4:0] {
        A_IDLE  = 5'b00001,
        A_SCALE = 5'b00010,
        A_SUB   = 5'b00100,
        A_DIV   = 5'b01000,
        A_FIN   = 5'b10000
    } astate_t;

    astate_t            state_reg;
    logic signed [31:0] a_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] mul_reg;
    logic [47:0]        q_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        den_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg;
    logic               done_reg;
    logic signed [31:0] res_reg;

    logic signed [63:0] adj;
    logic signed [63:0] scaled;
    logic signed [63:0] diff;
    logic [32:0]        rem_sh;
    logic               ge;
    logic [31:0]        abs_a;
    logic [31:0]        abs_y;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    assign adj    = prod_reg + (prod_reg[63] ? 64'sd65535 : 64'sd0);
    assign scaled = adj >>> 16;
    assign diff   = 64'(a_reg) - 64'(mul_reg);
    assign rem_sh = {rem_reg[31:0], q_reg[47]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign abs_a  = req.a[31] ? (~req.a + 32'd1) : req.a;
    assign abs_y  = req.y[31] ? (~req.y + 32'd1) : req.y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            a_reg     <= '0;
            prod_reg  <= '0;
            mul_reg   <= '0;
            q_reg     <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE:
                begin
                    if (req.start)
                    begin
                        a_reg <= req.a;
                        if (req.op == OP_MULSUB)
                        begin
                            prod_reg  <= req.x * req.y;
                            state_reg <= A_SCALE;
                        end
                        else if (req.y == 32'sd0)
                        begin
                            res_reg  <= '0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            q_reg     <= {abs_a, 16'd0};
                            rem_reg   <= '0;
                            den_reg   <= abs_y;
                            neg_reg   <= req.a[31] ^ req.y[31];
                            cnt_reg   <= '0;
                            state_reg <= A_DIV;
                        end
                    end
                end
                A_SCALE:
                begin
                    mul_reg   <= sat64(scaled);
                    state_reg <= A_SUB;
                end
                A_SUB:
                begin
                    res_reg   <= sat64(diff);
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                A_DIV:
                begin
                    rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                    q_reg   <= {q_reg[46:0], ge};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DIV_STEPS - 1))
                    begin
                        state_reg <= A_FIN;
                    end
                end
                A_FIN:
                begin
                    if (neg_reg)
                    begin
                        res_reg <= (q_reg > 48'h80000000) ? 32'sh80000000
                                                          : (~q_reg[31:0] + 32'd1);
                    end
                    else
                    begin
                        res_reg <= (q_reg > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : q_reg[31:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dlu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dlu_assertions (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input logic [1:0]        req_type,
    input logic              res_valid,
    input logic              res_stall,
    input logic [3:0]        index,
    input logic signed [31:0] solution,
    input logic [1:0]        status,
    input logic              last_result
);
    import dlu_pkg::*;

    // A pending result keeps the block busy.
    `DLU_ASSERT_NOW(a_busy_with_result, res_valid, req_stall, "result pending while ready")

    `DLU_ASSERT_NOW(a_status_single, res_valid && status != STAT_OK,
        last_result && index == 4'd0 && solution == 32'sd0, "bad status item")

    `DLU_ASSERT_NEXT(a_hold, res_valid && res_stall,
        res_valid && $stable(index) && $stable(solution) && $stable(status),
        "stalled result changed")

    `DLU_ASSERT_NEXT(a_factor_busy, req_valid && !req_stall && req_type == REQ_FACTOR,
        req_stall, "factor item did not occupy the block")

    `DLU_ASSERT_NEXT(a_more_results, res_valid && !res_stall && !last_result,
        req_stall, "block freed before the last result")

endmodule

bind dense_lu_solver dlu_assertions u_dlu_assertions (.*);

`default_nettype wire

@@ bench/dlu_checker.sv @@
`timescale 1ns / 1ps

module dlu_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic [1:0]                    req_type,
    input  logic [3:0]                    row,
    input  logic [3:0]                    col,
    input  logic signed [31:0]            value,
    input  logic                          last_element,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  logic [3:0]                    index,
    input  logic signed [31:0]            solution,
    input  logic [1:0]                    status,
    input  logic                          last_result,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [dlu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dlu_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                            errors,
    output int                            pending
);
    import dlu_pkg::*;

    typedef struct packed {
        logic [3:0]         idx;
        logic signed [31:0] sol;
        logic [1:0]         st;
        logic               fin;
    } sol_item_t;

    sol_item_t          sol_queue[$];
    logic signed [31:0] lu_mat[256];
    logic signed [31:0] rhs_vec[16];
    logic               lu_ok;
    logic [4:0]         msize;
    logic [16:0]        pmin;

    function automatic logic signed [31:0] clip(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return clip((longint'(a) * longint'(b)) / 65536);
    endfunction

    function automatic logic signed [31:0] divq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        if (b == 0)
            return 0;
        return clip((longint'(a) * 65536) / longint'(b));
    endfunction

    function automatic logic signed [31:0] subq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return clip(longint'(a) - longint'(b));
    endfunction

    function automatic int n_used();
        if (msize < 1)
            return 1;
        if (msize > 16)
            return 16;
        return msize;
    endfunction

    function automatic void push_status(input logic [1:0] st);
        sol_item_t e;
        e.idx = '0;
        e.sol = '0;
        e.st  = st;
        e.fin = 1'b1;
        sol_queue.push_back(e);
    endfunction

    function automatic void run_factor();
        int n;
        logic signed [31:0] p;
        longint mag;
        n = n_used();
        lu_ok = 1'b0;
        for (int k = 0; k < n; k++)
        begin
            p = lu_mat[k*16+k];
            mag = (p < 0) ? -longint'(p) : longint'(p);
            if (p == 0 || mag < longint'(pmin))
            begin
                push_status(STAT_SINGULAR);
                return;
            end
            for (int i = k + 1; i < n; i++)
                lu_mat[i*16+k] = divq(lu_mat[i*16+k], p);
            for (int i = k + 1; i < n; i++)
                for (int j = k + 1; j < n; j++)
                    lu_mat[i*16+j] = subq(lu_mat[i*16+j],
                                          mulq(lu_mat[i*16+k], lu_mat[k*16+j]));
        end
        lu_ok = 1'b1;
        push_status(STAT_OK);
    endfunction

    function automatic void run_solve();
        int n;
        sol_item_t e;
        n = n_used();
        if (!lu_ok)
        begin
            push_status(STAT_NO_FACTOR);
            return;
        end
        for (int i = 1; i < n; i++)
            for (int j = 0; j < i; j++)
                rhs_vec[i] = subq(rhs_vec[i], mulq(rhs_vec[j], lu_mat[i*16+j]));
        for (int i = n - 1; i >= 0; i--)
        begin
            for (int j = n - 1; j > i; j--)
                rhs_vec[i] = subq(rhs_vec[i], mulq(rhs_vec[j], lu_mat[i*16+j]));
            rhs_vec[i] = divq(rhs_vec[i], lu_mat[i*16+i]);
        end
        for (int i = 0; i < n; i++)
        begin
            e.idx = i[3:0];
            e.sol = rhs_vec[i];
            e.st  = STAT_OK;
            e.fin = (i == n - 1);
            sol_queue.push_back(e);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sol_item_t e;
        if (!rst_n)
        begin
            sol_queue.delete();
            lu_ok   = 1'b0;
            msize   = 5'd16;
            pmin    = 17'd1;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (sol_queue.size() == 0)
                begin
                    $display("%0t unexpected result: idx %0d sol %h st %0d last %0b",
                             $time, index, solution, status, last_result);
                    errors <= errors + 1;
                end
                else
                begin
                    e = sol_queue.pop_front();
                    if (index !== e.idx || solution !== e.sol || status !== e.st
                        || last_result !== e.fin)
                    begin
                        $display("%0t mismatch: expected idx %0d sol %h st %0d last %0b",
                                 $time, e.idx, e.sol, e.st, e.fin);
                        $display("%0t           actual   idx %0d sol %h st %0d last %0b",
                                 $time, index, solution, status, last_result);
                        errors <= errors + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MATRIX_SIZE)
                begin
                    msize = cfg_data[4:0];
                    lu_ok = 1'b0;
                end
                else if (cfg_index == CFG_PIVOT_MIN)
                    pmin = cfg_data;
            end
            if (req_valid && !req_stall)
            begin
                case (req_type)
                    REQ_WRITE_MAT:
                    begin
                        lu_mat[{row, col}] = value;
                        lu_ok = 1'b0;
                    end
                    REQ_FACTOR:
                        run_factor();
                    REQ_WRITE_RHS:
                    begin
                        rhs_vec[row] = value;
                        if (last_element)
                            run_solve();
                    end
                    default:
                        ;
                endcase
            end
            pending <= sol_queue.size();
        end
    end

endmodule

@@ bench/tb_dense_lu_solver.sv @@
`timescale 1ns / 1ps

module tb_dense_lu_solver;
    import dlu_pkg::*;

    localparam logic [1:0]           REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE   = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic [1:0]           req_type = '0;
    logic [3:0]           row = '0;
    logic [3:0]           col = '0;
    logic signed [31:0]   value = '0;
    logic                 last_element = 1'b0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic [3:0]           index;
    logic signed [31:0]   solution;
    logic [1:0]           status;
    logic                 last_result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    int                   errors;
    int                   pending;

    int send_idle = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int items_sent = 0;
    int cur_n = 16;

    dense_lu_solver DUT (.*);

    dlu_checker u_checker (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_served < hold_requests)
        begin
            hold_served++;
            hold_left = 4000;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #2_000_000;
        $display("tb_dense_lu_solver: errors");
        $finish;
    end

    task automatic offer(input logic [1:0] t, input logic [3:0] r, input logic [3:0] c,
                         input logic signed [31:0] v, input logic lst);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        req_type     <= t;
        row          <= r;
        col          <= c;
        value        <= v;
        last_element <= lst;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_quiet();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input logic [4:0] raw);
        wait_quiet();
        cfg_write(CFG_MATRIX_SIZE, raw);
        cur_n = (raw < 1) ? 1 : (raw > 16) ? 16 : raw;
    endtask

    task automatic load_2x2(input logic signed [31:0] a, input logic signed [31:0] b,
                            input logic signed [31:0] c, input logic signed [31:0] d);
        offer(REQ_WRITE_MAT, 0, 0, a, 1'b0);
        offer(REQ_WRITE_MAT, 0, 1, b, 1'b1);
        offer(REQ_WRITE_MAT, 1, 0, c, 1'b0);
        offer(REQ_WRITE_MAT, 1, 1, d, 1'b0);
    endtask

    function automatic logic signed [31:0] rand_word();
        return $urandom;
    endfunction

    task automatic noise_item();
        logic [1:0] t;
        t = $urandom_range(3);
        if (t == REQ_FACTOR)
            t = REQ_UNUSED;
        offer(t, $urandom, $urandom, rand_word(), (t == REQ_WRITE_RHS) ? 1'b0 : $urandom);
    endtask

    task automatic solve_run(input bit pressure);
        logic [4:0] raw;
        int pick;
        bit wild;
        logic signed [31:0] v;
        pick = $urandom_range(99);
        if (pick < 75)
            raw = 5'($urandom_range(3, 1));
        else if (pick < 95)
            raw = 5'($urandom_range(5, 4));
        else
            raw = 5'd0;
        if (pressure)
            raw = 5'd3;
        set_size(raw);
        if ($urandom_range(99) < 30)
        begin
            pick = $urandom_range(3);
            cfg_write(CFG_PIVOT_MIN, (pick == 0) ? 17'd0 : (pick == 1) ? 17'd1 :
                                     (pick == 2) ? 17'd65536 : $urandom_range(65536));
        end
        if ($urandom_range(99) < 10)
            cfg_write(CFG_NONE, $urandom);
        wild = ($urandom_range(99) < 10);
        for (int r = 0; r < cur_n; r++)
            for (int c = 0; c < cur_n; c++)
            begin
                if (wild)
                    v = rand_word();
                else if (r == c)
                begin
                    v = (2 * cur_n + 1) * 65536 + $urandom_range(65535);
                    if ($urandom_range(1))
                        v = -v;
                end
                else
                    v = $signed($urandom_range(131072)) - 65536;
                offer(REQ_WRITE_MAT, r, c, v, $urandom);
            end
        if ($urandom_range(99) < 25)
            noise_item();
        offer(REQ_FACTOR, $urandom, $urandom, rand_word(), $urandom);
        if ($urandom_range(99) < 15)
            offer(REQ_WRITE_MAT, $urandom, $urandom, rand_word(), 1'b0);
        for (int i = 0; i < cur_n; i++)
            offer(REQ_WRITE_RHS, i, $urandom, wild ? rand_word() :
                  $signed($urandom_range(1 << 20)) - (1 << 19), 1'b0);
        if (pressure)
            hold_requests++;
        offer(REQ_WRITE_RHS, $urandom_range(cur_n - 1), $urandom,
              $signed($urandom_range(1 << 20)) - (1 << 19), 1'b1);
        if (pressure)
            repeat (12) noise_item();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(REQ_WRITE_RHS, 0, 0, 32'sh7FFFFFFF, 1'b1);
        offer(REQ_UNUSED, 4'hF, 4'hF, 32'sh80000000, 1'b1);
        set_size(5'd2);
        load_2x2(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
        offer(REQ_FACTOR, 0, 0, 0, 1'b1);
        offer(REQ_WRITE_RHS, 0, 0, 32'sh80000000, 1'b0);
        offer(REQ_WRITE_RHS, 1, 0, 32'sh7FFFFFFF, 1'b1);
        offer(REQ_WRITE_MAT, 0, 0, 0, 1'b0);
        offer(REQ_FACTOR, 0, 0, 0, 1'b0);
        offer(REQ_WRITE_RHS, 1, 0, 32'sh00010000, 1'b1);
        load_2x2(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000);
        offer(REQ_FACTOR, 0, 0, 0, 1'b0);
        wait_quiet();
        cfg_write(CFG_PIVOT_MIN, 17'd65536);
        load_2x2(32'sh8000, 0, 0, 32'sh10000);
        offer(REQ_FACTOR, 0, 0, 0, 1'b0);
        offer(REQ_WRITE_MAT, 0, 0, 32'sh10000, 1'b0);
        offer(REQ_FACTOR, 0, 0, 0, 1'b0);
        set_size(5'd2);
        offer(REQ_WRITE_RHS, 0, 0, 32'sh10000, 1'b1);
        wait_quiet();
        cfg_write(CFG_PIVOT_MIN, 17'd0);
        offer(REQ_WRITE_MAT, 0, 0, 0, 1'b0);
        offer(REQ_FACTOR, 0, 0, 0, 1'b0);
        wait_quiet();
        cfg_write(CFG_PIVOT_MIN, 17'd1);

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_quiet();
            case (ph)
                0: begin send_idle = 0;  stall_pct = 0;  end
                1: begin send_idle = 56; stall_pct = 0;  end
                2: begin send_idle = 0;  stall_pct = 56; end
                default: begin send_idle = 38; stall_pct = 38; end
            endcase
            if (ph == 0)
                solve_run(1'b1);
            while (items_sent < 30 + 20 * (ph + 1))
                solve_run(1'b0);
        end

        wait_quiet();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb_dense_lu_solver: clean");
        else
            $display("tb_dense_lu_solver: errors");
        $finish;
    end

endmodule
